// ----- rtl/gbn_pkg.sv -----
// Shared types and constants of the go-back-N sender.
// No dependencies; every module of the block imports this package.
`default_nettype none

package gbn_pkg;

   // Sizing of the outstanding window, the waiting queue and the command queue.
   localparam int WINDOW_SLOTS = 4;
   localparam int WAIT_DEPTH   = 16;
   localparam int CMDQ_DEPTH   = 2;

   localparam int WIN_CNT_W  = $clog2(WINDOW_SLOTS + 1);
   localparam int WIN_IDX_W  = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
   localparam int WAIT_PTR_W = $clog2(WAIT_DEPTH);
   localparam int WAIT_CNT_W = $clog2(WAIT_DEPTH + 1);
   localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   localparam int SEQ_W   = 32;
   localparam int INDEX_W = 8;
   localparam int LEN_W   = 8;
   localparam int LIMIT_W = 3;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4);

   // Request codes on the input channel.
   localparam logic [1:0] REQ_SEND    = 2'd0;
   localparam logic [1:0] REQ_ACK     = 2'd1;
   localparam logic [1:0] REQ_TIMEOUT = 2'd2;

   typedef enum logic [1:0] {
      CMD_SEND    = 2'd0,
      CMD_ACK     = 2'd1,
      CMD_TIMEOUT = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_NEW    = 2'd0,
      KIND_RETX   = 2'd1,
      KIND_REJECT = 2'd2
   } kind_type;

   typedef struct packed {
      logic [SEQ_W-1:0]   seq;
      logic [INDEX_W-1:0] idx;
      logic [LEN_W-1:0]   len;
   } desc_type;

   // For acks and timeouts the sequence field carries the number to match.
   typedef struct packed {
      cmd_type  cmd;
      desc_type desc;
   } cmd_entry_type;

   typedef struct packed {
      logic     valid;
      kind_type kind;
      desc_type desc;
      logic     last;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/go_back_n_sender_unit.sv -----
// Top level of the go-back-N sender: window limit register, front end,
// command queue and back end. Depends on gbn_pkg, gbn_front, gbn_cmdq, gbn_back.
`default_nettype none

// How the block is used.
// A request is taken at a rising clock edge where start is high and busy is
// low. It carries a request type (send, ack received, timer expired) and the
// fields that type needs; the other fields are ignored. Unknown types are
// accepted and dropped without any result.
// Results come out on the rsp_ ports, each valid for exactly one cycle while
// rsp_valid is high; rsp_last marks the final result that one item causes.
// The receiver cannot hold results off, so results simply leave one a cycle.
// Accepted items go into a two-entry command queue; busy is high only while
// that queue is full, so a new item is usually taken while the back end is
// still issuing results for an earlier one.
// From an idle block a first result passes the command queue, the window
// update and the registered output; a reject skips the window update. A send
// or a matching ack then refills the window from the waiting queue with a
// result per frame moved; a matching timeout resends every outstanding frame.
// The user must write the window limit through csr_we/csr_wdata only while
// the block is idle; the block itself does not enforce this. Reset clears the
// window, the waiting queue and the command queue and sets the limit to four.

module go_back_n_sender_unit
   import gbn_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_type,
   input  logic [SEQ_W-1:0]    req_frame_seq,
   input  logic [INDEX_W-1:0]  req_buffer_index,
   input  logic [LEN_W-1:0]    req_frame_length,
   input  logic [SEQ_W-1:0]    req_ack_number,
   input  logic [SEQ_W-1:0]    req_timeout_seq,
   output logic                rsp_valid,
   output logic [1:0]          rsp_result_kind,
   output logic [SEQ_W-1:0]    rsp_out_seq,
   output logic [INDEX_W-1:0]  rsp_out_buffer_index,
   output logic [LEN_W-1:0]    rsp_out_length,
   output logic                rsp_last,
   input  logic                csr_we,
   input  logic [LIMIT_W-1:0]  csr_wdata
);

   logic [LIMIT_W-1:0] limit_ff;
   logic               q_full;
   logic               q_empty;
   logic               push;
   logic               pop;
   cmd_entry_type      push_data;
   cmd_entry_type      pop_data;
   rsp_type            rsp;

   // The window limit register; the back end clamps it to the legal range.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   // The front end turns each request into a queue command.
   gbn_front u_front (
      .start            (start),
      .req_type         (req_type),
      .req_frame_seq    (req_frame_seq),
      .req_buffer_index (req_buffer_index),
      .req_frame_length (req_frame_length),
      .req_ack_number   (req_ack_number),
      .req_timeout_seq  (req_timeout_seq),
      .q_full           (q_full),
      .busy             (busy),
      .push             (push),
      .push_data        (push_data)
   );

   // The queue lets the front end take items while the back end is busy.
   gbn_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty),
      .full      (q_full)
   );

   // The back end owns the window and the waiting ring and emits results.
   gbn_back u_back (
      .clock        (clock),
      .reset        (reset),
      .window_limit (limit_ff),
      .q_empty      (q_empty),
      .q_data       (pop_data),
      .pop          (pop),
      .rsp          (rsp)
   );

   assign rsp_valid            = rsp.valid;
   assign rsp_result_kind      = rsp.kind;
   assign rsp_out_seq          = rsp.desc.seq;
   assign rsp_out_buffer_index = rsp.desc.idx;
   assign rsp_out_length       = rsp.desc.len;
   assign rsp_last             = rsp.last;

endmodule

`default_nettype wire

// ----- rtl/gbn_front.sv -----
// Front end: accepts requests and classifies them into queue commands.
// Depends on gbn_pkg.
`default_nettype none

module gbn_front
   import gbn_pkg::*;
(
   input  logic                start,
   input  logic [1:0]          req_type,
   input  logic [SEQ_W-1:0]    req_frame_seq,
   input  logic [INDEX_W-1:0]  req_buffer_index,
   input  logic [LEN_W-1:0]    req_frame_length,
   input  logic [SEQ_W-1:0]    req_ack_number,
   input  logic [SEQ_W-1:0]    req_timeout_seq,
   input  logic                q_full,
   output logic                busy,
   output logic                push,
   output cmd_entry_type       push_data
);

   logic accept;

   assign busy   = q_full;
   assign accept = start && !q_full;

   // Unknown request types are dropped here and never reach the back end.
   always_comb begin
      push           = 1'b0;
      push_data.cmd  = CMD_SEND;
      push_data.desc = '{seq: req_frame_seq, idx: req_buffer_index, len: req_frame_length};
      unique case (req_type)
         REQ_SEND: begin
            push = accept;
         end
         REQ_ACK: begin
            push               = accept;
            push_data.cmd      = CMD_ACK;
            push_data.desc.seq = req_ack_number;
         end
         REQ_TIMEOUT: begin
            push               = accept;
            push_data.cmd      = CMD_TIMEOUT;
            push_data.desc.seq = req_timeout_seq;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/gbn_cmdq.sv -----
// Short command queue between the front end and the back end.
// Depends on gbn_pkg.
`default_nettype none

module gbn_cmdq
   import gbn_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cmd_entry_type push_data,
   input  logic          pop,
   output cmd_entry_type pop_data,
   output logic          empty,
   output logic          full
);

   cmd_entry_type           entries_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]   count_ff,  count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/gbn_back.sv -----
// Back end: holds the window and the waiting ring and issues transmit results.
// Depends on gbn_pkg; fed by gbn_cmdq.
`default_nettype none

module gbn_back
   import gbn_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [LIMIT_W-1:0] window_limit,
   input  logic               q_empty,
   input  cmd_entry_type      q_data,
   output logic               pop,
   output rsp_type            rsp
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_REFILL = 3'b010,
      ST_RETX   = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   desc_type               win_ff [WINDOW_SLOTS];
   desc_type               win_in [WINDOW_SLOTS];
   logic [WIN_CNT_W-1:0]   win_cnt_ff, win_cnt_in;
   logic [WIN_IDX_W-1:0]   rtx_ff, rtx_in;
   desc_type               wait_ff [WAIT_DEPTH];
   logic [WAIT_PTR_W-1:0]  head_ff, head_in;
   logic [WAIT_PTR_W-1:0]  tail_ff, tail_in;
   logic [WAIT_CNT_W-1:0]  wait_cnt_ff, wait_cnt_in;
   logic                   wait_we;
   rsp_type                rsp_ff, rsp_in;

   logic [WIN_CNT_W-1:0]   limit;
   logic                   ack_hit;
   logic [WIN_IDX_W-1:0]   ack_pos;
   logic                   tmo_hit;
   logic                   can_fill;
   logic                   fill_last;
   logic                   wait_full;

   // Zero behaves as one, values above the slot count as the slot count.
   always_comb begin
      if (window_limit == '0) begin
         limit = WIN_CNT_W'(1);
      end else if (32'(window_limit) > WINDOW_SLOTS) begin
         limit = WIN_CNT_W'(WINDOW_SLOTS);
      end else begin
         limit = WIN_CNT_W'(window_limit);
      end
   end

   // Oldest matching window entry for an ack, any match for a timeout.
   always_comb begin
      ack_hit = 1'b0;
      ack_pos = '0;
      tmo_hit = 1'b0;
      for (int i = 0; i < WINDOW_SLOTS; i++) begin
         if (WIN_CNT_W'(i) < win_cnt_ff && win_ff[i].seq == q_data.desc.seq) begin
            tmo_hit = 1'b1;
            if (!ack_hit) begin
               ack_hit = 1'b1;
               ack_pos = WIN_IDX_W'(i);
            end
         end
      end
   end

   assign wait_full = (wait_cnt_ff == WAIT_CNT_W'(WAIT_DEPTH));
   assign can_fill  = (win_cnt_ff < limit) && (wait_cnt_ff != '0);
   assign fill_last = (win_cnt_ff + 1'b1 >= limit) || (wait_cnt_ff == WAIT_CNT_W'(1));
   assign pop       = (state_ff == ST_IDLE) && !q_empty;

   always_comb begin
      state_in    = state_ff;
      win_in      = win_ff;
      win_cnt_in  = win_cnt_ff;
      rtx_in      = rtx_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      wait_cnt_in = wait_cnt_ff;
      wait_we     = 1'b0;
      rsp_in      = '{valid: 1'b0, kind: KIND_NEW, desc: q_data.desc, last: 1'b0};

      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               unique case (q_data.cmd)
                  CMD_SEND: begin
                     if (wait_full) begin
                        rsp_in.valid = 1'b1;
                        rsp_in.kind  = KIND_REJECT;
                        rsp_in.last  = 1'b1;
                     end else begin
                        wait_we     = 1'b1;
                        tail_in     = (tail_ff == WAIT_PTR_W'(WAIT_DEPTH - 1)) ?
                                      '0 : tail_ff + 1'b1;
                        wait_cnt_in = wait_cnt_ff + 1'b1;
                        state_in    = ST_REFILL;
                     end
                  end
                  CMD_ACK: begin
                     if (ack_hit) begin
                        for (int k = 0; k < WINDOW_SLOTS; k++) begin
                           if (k + int'(ack_pos) + 1 < WINDOW_SLOTS) begin
                              win_in[k] = win_ff[WIN_IDX_W'(k + int'(ack_pos) + 1)];
                           end
                        end
                        win_cnt_in = win_cnt_ff - (WIN_CNT_W'(ack_pos) + 1'b1);
                        state_in   = ST_REFILL;
                     end
                  end
                  CMD_TIMEOUT: begin
                     if (tmo_hit) begin
                        rtx_in   = '0;
                        state_in = ST_RETX;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_REFILL: begin
            if (can_fill) begin
               win_in[win_cnt_ff[WIN_IDX_W-1:0]] = wait_ff[head_ff];
               win_cnt_in  = win_cnt_ff + 1'b1;
               head_in     = (head_ff == WAIT_PTR_W'(WAIT_DEPTH - 1)) ? '0 : head_ff + 1'b1;
               wait_cnt_in = wait_cnt_ff - 1'b1;
               rsp_in      = '{valid: 1'b1, kind: KIND_NEW, desc: wait_ff[head_ff],
                               last: fill_last};
               if (fill_last) begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RETX: begin
            rsp_in.valid = 1'b1;
            rsp_in.kind  = KIND_RETX;
            rsp_in.desc  = win_ff[rtx_ff];
            rsp_in.last  = (WIN_CNT_W'(rtx_ff) + 1'b1 == win_cnt_ff);
            rtx_in       = rtx_ff + 1'b1;
            if (rsp_in.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Of the result register only the strobe is reset; the result payload just follows.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         win_cnt_ff   <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         wait_cnt_ff  <= '0;
         rsp_ff.valid <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_cnt_ff   <= win_cnt_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         wait_cnt_ff  <= wait_cnt_in;
         rsp_ff.valid <= rsp_in.valid;
      end
      rsp_ff.kind <= rsp_in.kind;
      rsp_ff.desc <= rsp_in.desc;
      rsp_ff.last <= rsp_in.last;
   end

   always_ff @(posedge clock) begin
      win_ff      <= win_in;
      rtx_ff      <= rtx_in;
      if (wait_we) begin
         wait_ff[tail_ff] <= q_data.desc;
      end
   end

   assign rsp = rsp_ff;

`ifndef NO_ASSERTIONS
   a_win_bound : assert property (@(posedge clock) disable iff (reset)
      32'(win_cnt_ff) <= WINDOW_SLOTS)
      else $error("window count above slot count");

   a_wait_bound : assert property (@(posedge clock) disable iff (reset)
      32'(wait_cnt_ff) <= WAIT_DEPTH)
      else $error("waiting count above queue depth");

   a_retx_index : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RETX |-> WIN_CNT_W'(rtx_ff) < win_cnt_ff)
      else $error("retransmit index outside window");

   a_reject_last : assert property (@(posedge clock) disable iff (reset)
      rsp_ff.valid && rsp_ff.kind == KIND_REJECT |-> rsp_ff.last)
      else $error("reject result not marked last");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for go_back_n_sender_unit: directed items, then random traffic
// under every window limit, checked against a cycle-free model of the sender or the plan.
// Depends on gbn_pkg and the go_back_n_sender_unit RTL.

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import gbn_pkg::*;

   // Request code that the block must accept and drop without any result.
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // Cycles allowed for items that cause no result to drain out of the command
   // queue.
   localparam int SETTLE_CYCLES = 32;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int REPORT_LIMIT  = 10;
   localparam int PHASE_ITEMS   = 34;

   // Window limits used by the random phases. All eight register values show up,
   // so zero (acts as one) and values above the slot count are both exercised.
   localparam logic [LIMIT_W-1:0] PHASE_LIMITS [9] =
      '{3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd4, 3'd6, 3'd1};

   typedef struct {
      logic [1:0]       rtype;
      desc_type         frame;
      logic [SEQ_W-1:0] ack;
      logic [SEQ_W-1:0] tseq;
   } sender_req_type;

   typedef struct {
      kind_type kind;
      desc_type frame;
      logic     last;
   } tx_cmd_type;

   // One row of the directed plan. A typed row carries its expected outcome
   // directly: either nothing, or one result that echoes the row's frame.
   typedef struct {
      sender_req_type req;
      int             reps;
      bit             typed;
      int             exp_n;
      kind_type       exp_kind;
   } plan_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [1:0]          req_type = REQ_SEND;
   logic [SEQ_W-1:0]    req_frame_seq = '0;
   logic [INDEX_W-1:0]  req_buffer_index = '0;
   logic [LEN_W-1:0]    req_frame_length = '0;
   logic [SEQ_W-1:0]    req_ack_number = '0;
   logic [SEQ_W-1:0]    req_timeout_seq = '0;
   logic                rsp_valid;
   logic [1:0]          rsp_result_kind;
   logic [SEQ_W-1:0]    rsp_out_seq;
   logic [INDEX_W-1:0]  rsp_out_buffer_index;
   logic [LEN_W-1:0]    rsp_out_length;
   logic                rsp_last;
   logic                csr_we = 1'b0;
   logic [LIMIT_W-1:0]  csr_wdata = LIMIT_RESET;

   // Shadow of the sender: outstanding window, waiting queue and the limit.
   desc_type           win_frames[$];
   desc_type           wait_frames[$];
   logic [LIMIT_W-1:0] limit_shadow = LIMIT_RESET;

   // Results caused by the item just accepted, and all results still owed.
   tx_cmd_type   step_out[$];
   tx_cmd_type   pending_tx[$];
   plan_row_type plan[$];

   logic [SEQ_W-1:0] next_seq = '0;
   int burst_left     = 0;
   int cycle_count    = 0;
   int mismatch_count = 0;
   int items_accepted = 0;
   int results_seen   = 0;
   int retx_seen      = 0;
   int rejects_seen   = 0;

   go_back_n_sender_unit dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_type             (req_type),
      .req_frame_seq        (req_frame_seq),
      .req_buffer_index     (req_buffer_index),
      .req_frame_length     (req_frame_length),
      .req_ack_number       (req_ack_number),
      .req_timeout_seq      (req_timeout_seq),
      .rsp_valid            (rsp_valid),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_out_seq          (rsp_out_seq),
      .rsp_out_buffer_index (rsp_out_buffer_index),
      .rsp_out_length       (rsp_out_length),
      .rsp_last             (rsp_last),
      .csr_we               (csr_we),
      .csr_wdata            (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog. A missing result shows up here, since the end of the run waits
   // for every owed result.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL go_back_n_sender_unit");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sender model
   // ---------------------------------------------------------------------

   // Effective window size: zero behaves as one, anything above the number of
   // slots is clipped to the slot count.
   function automatic int window_cap();
      int cap;
      cap = int'(limit_shadow);
      if (cap == 0) cap = 1;
      if (cap > WINDOW_SLOTS) cap = WINDOW_SLOTS;
      return cap;
   endfunction

   function automatic void emit_tx(kind_type kind, desc_type frame);
      tx_cmd_type c;
      c.kind  = kind;
      c.frame = frame;
      c.last  = 1'b0;
      step_out = {step_out, c};
   endfunction

   // Move waiting frames into the window, oldest first, while it has room.
   // A window that is already over a lowered limit simply takes nothing.
   function automatic void refill_window();
      desc_type d;
      while (win_frames.size() < window_cap() && wait_frames.size() > 0) begin
         d = wait_frames.pop_front();
         win_frames = {win_frames, d};
         emit_tx(KIND_NEW, d);
      end
   endfunction

   // Works out the results of one accepted item into step_out and updates the
   // shadow state. The final result of the item carries the last flag.
   function automatic void predict_sender(sender_req_type r);
      int hit;
      hit = -1;
      step_out.delete();
      case (r.rtype)
         REQ_SEND: begin
            // A full waiting queue bounces the frame back; the window is
            // left alone in that case.
            if (wait_frames.size() >= WAIT_DEPTH) begin
               emit_tx(KIND_REJECT, r.frame);
            end else begin
               wait_frames = {wait_frames, r.frame};
               refill_window();
            end
         end
         REQ_ACK: begin
            // Cumulative ack: the oldest matching entry and everything older go.
            for (int i = 0; i < win_frames.size() && hit < 0; i++)
               if (win_frames[i].seq == r.ack) hit = i;
            if (hit >= 0) begin
               repeat (hit + 1) void'(win_frames.pop_front());
               refill_window();
            end
         end
         REQ_TIMEOUT: begin
            // Any match resends the whole window in order.
            foreach (win_frames[i])
               if (win_frames[i].seq == r.tseq) hit = i;
            if (hit >= 0)
               foreach (win_frames[i]) emit_tx(KIND_RETX, win_frames[i]);
         end
         default: ;
      endcase
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------

   function automatic void report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("mismatch at cycle %0d: %s", cycle_count, what);
   endfunction

   // Results cannot be held off, so each valid cycle is one result; it is
   // matched against the oldest owed result.
   always @(posedge clock) begin : check_results
      tx_cmd_type want;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (rsp_result_kind == KIND_RETX) retx_seen++;
         if (rsp_result_kind == KIND_REJECT) rejects_seen++;
         if (pending_tx.size() == 0) begin
            report_mismatch($sformatf(
               "result with none owed: kind %0d seq %h idx %h len %h last %b",
               rsp_result_kind, rsp_out_seq, rsp_out_buffer_index, rsp_out_length,
               rsp_last));
         end else begin
            want = pending_tx.pop_front();
            if (rsp_result_kind !== want.kind || rsp_out_seq !== want.frame.seq ||
                rsp_out_buffer_index !== want.frame.idx || rsp_out_length !== want.frame.len ||
                rsp_last !== want.last)
               report_mismatch($sformatf(
                  "expected kind %0d seq %h idx %h len %h last %b, got %0d %h %h %h %b",
                  want.kind, want.frame.seq, want.frame.idx, want.frame.len, want.last,
                  rsp_result_kind, rsp_out_seq, rsp_out_buffer_index, rsp_out_length,
                  rsp_last));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   // Presents one item and holds it until the block takes it. busy is read
   // right after the edge, so it is the value that decided the handshake.
   task automatic issue_req(sender_req_type r, bit typed, int exp_n, kind_type exp_kind);
      tx_cmd_type c;
      start            <= 1'b1;
      req_type         <= r.rtype;
      req_frame_seq    <= r.frame.seq;
      req_buffer_index <= r.frame.idx;
      req_frame_length <= r.frame.len;
      req_ack_number   <= r.ack;
      req_timeout_seq  <= r.tseq;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_accepted++;
      predict_sender(r);
      // Typed rows replace the model's answer with the value written in the
      // plan; the model still runs so that its state stays in step.
      if (typed) begin
         step_out.delete();
         if (exp_n > 0) begin
            c.kind  = exp_kind;
            c.frame = r.frame;
            c.last  = 1'b1;
            step_out = {step_out, c};
         end
      end
      foreach (step_out[k]) pending_tx = {pending_tx, step_out[k]};
   endtask

   // The sender runs in bursts. Between bursts start drops for a random number
   // of cycles, so the gaps land on every stage of the back end's work.
   task automatic pace();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(0, 15);
      end
   endtask

   // The limit register is only written while the block is idle: all owed
   // results are out and items without results have had time to drain.
   task automatic set_limit(logic [LIMIT_W-1:0] value);
      start <= 1'b0;
      while (pending_tx.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      limit_shadow = value;
      csr_we <= 1'b0;
   endtask

   function automatic void add_row(logic [1:0] rtype, logic [SEQ_W-1:0] seq,
                                   logic [INDEX_W-1:0] idx, logic [LEN_W-1:0] len,
                                   logic [SEQ_W-1:0] num, int reps, bit typed, int exp_n,
                                   kind_type exp_kind);
      plan_row_type row;
      row.req.rtype     = rtype;
      row.req.frame.seq = seq;
      row.req.frame.idx = idx;
      row.req.frame.len = len;
      row.req.ack       = num;
      row.req.tseq      = num;
      row.reps          = reps;
      row.typed         = typed;
      row.exp_n         = exp_n;
      row.exp_kind      = exp_kind;
      plan = {plan, row};
   endfunction

   // Directed part, run with the reset limit of four. The window fills with
   // the field extremes, then sixteen frames fill the waiting queue, the next
   // send bounces, and acks and timeouts that miss or hit are tried on that
   // full state.
   function automatic void build_plan();
      add_row(REQ_SEND,    32'h0,         8'h00, 8'h00, 32'h0,         1, 1, 1, KIND_NEW);
      add_row(REQ_SEND,    32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'h0,         1, 1, 1, KIND_NEW);
      add_row(REQ_SEND,    32'h1,         8'h55, 8'hAA, 32'h0,         1, 1, 1, KIND_NEW);
      add_row(REQ_SEND,    32'h2,         8'hAA, 8'h55, 32'h0,         1, 1, 1, KIND_NEW);
      // Window is full: these frames only wait.
      add_row(REQ_SEND,    32'h100,       8'h3C, 8'hC3, 32'h0,        16, 1, 0, KIND_NEW);
      // Waiting queue is full: the frame comes straight back as a reject.
      add_row(REQ_SEND,    32'hDEAD,      8'h01, 8'h02, 32'h0,         1, 1, 1, KIND_REJECT);
      add_row(REQ_TIMEOUT, 32'h0,         8'h00, 8'h00, 32'h1234_5678, 1, 1, 0, KIND_NEW);
      add_row(REQ_ACK,     32'h0,         8'h00, 8'h00, 32'h8000_0000, 1, 1, 0, KIND_NEW);
      add_row(REQ_TIMEOUT, 32'h0,         8'h00, 8'h00, 32'hFFFF_FFFF, 1, 0, 0, KIND_NEW);
      add_row(REQ_ACK,     32'h0,         8'h00, 8'h00, 32'hFFFF_FFFF, 1, 0, 0, KIND_NEW);
      add_row(REQ_UNUSED,  32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1, 1, 0, KIND_NEW);
      add_row(REQ_SEND,    32'h200,       8'h10, 8'h20, 32'h0,         1, 1, 0, KIND_NEW);
      // Ack of the newest entry empties the window, which refills to four.
      add_row(REQ_ACK,     32'h0,         8'h00, 8'h00, 32'h101,       1, 0, 0, KIND_NEW);
   endfunction

   // Random items are mostly well-formed: sends with rising sequence numbers,
   // acks and timeouts that name a frame actually in the window. The rest is
   // noise: misses, unknown request types and sends with arbitrary numbers.
   // Fields that the request type ignores carry random values.
   function automatic sender_req_type random_req(int send_pct);
      sender_req_type r;
      int pick;
      r.rtype     = REQ_SEND;
      r.frame.seq = $urandom();
      r.frame.idx = INDEX_W'($urandom());
      r.frame.len = LEN_W'($urandom());
      r.ack       = $urandom();
      r.tseq      = $urandom();
      if ($urandom_range(0, 99) < send_pct) begin
         r.frame.seq = next_seq;
         next_seq++;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            r.rtype = REQ_ACK;
            if (win_frames.size() > 0)
               r.ack = win_frames[$urandom_range(0, win_frames.size() - 1)].seq;
         end else if (pick < 75) begin
            r.rtype = REQ_TIMEOUT;
            if (win_frames.size() > 0)
               r.tseq = win_frames[$urandom_range(0, win_frames.size() - 1)].seq;
         end else if (pick < 88) begin
            r.rtype = ($urandom_range(0, 1) == 0) ? REQ_ACK : REQ_TIMEOUT;
         end else if (pick < 94) begin
            r.rtype = REQ_UNUSED;
         end
      end
      return r;
   endfunction

   initial begin : stimulus
      sender_req_type r;
      plan_row_type   row;
      int             send_pct;

      build_plan();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[p]) begin
         row = plan[p];
         for (int k = 0; k < row.reps; k++) begin
            r = row.req;
            r.frame.seq = row.req.frame.seq + k;
            pace();
            issue_req(r, row.typed, row.exp_n, row.exp_kind);
         end
      end

      // Random phases. The window is left as it stands between phases, so a
      // lower limit often arrives while the window holds more than it allows.
      // Some phases start near the top of the sequence space to wrap it, and
      // some run without any gaps at all.
      foreach (PHASE_LIMITS[ph]) begin
         set_limit(PHASE_LIMITS[ph]);
         send_pct = $urandom_range(40, 85);
         next_seq = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFF0 : $urandom();
         if ($urandom_range(0, 3) == 0) burst_left = PHASE_ITEMS;
         repeat (PHASE_ITEMS) begin
            pace();
            issue_req(random_req(send_pct), 1'b0, 0, KIND_NEW);
         end
      end

      // Drain: every owed result must arrive before the watchdog fires, then a
      // quiet stretch catches any stray result.
      start <= 1'b0;
      while (pending_tx.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d items across %0d window limit settings and the reset limit.",
               items_accepted, $size(PHASE_LIMITS));
      $display("Checked %0d results, %0d retransmissions and %0d rejects; %0d mismatches.",
               results_seen, retx_seen, rejects_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASS go_back_n_sender_unit");
      end else begin
         $display("FAIL go_back_n_sender_unit");
      end
      $finish;
   end

endmodule
